// ===== rtl/bpd_pkg.sv =====
`timescale 1ns / 1ps
package bpd_pkg;

  // Input function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_PAL   = 2'd1;
  localparam logic [1:0] FUNC_PIX   = 2'd2;

  // Pixel formats
  localparam logic [2:0] FMT_PAL4  = 3'd0;
  localparam logic [2:0] FMT_PAL8  = 3'd1;
  localparam logic [2:0] FMT_RGB16 = 3'd2;
  localparam logic [2:0] FMT_RGB24 = 3'd3;
  localparam logic [2:0] FMT_RGB32 = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_FMT    = 3'd0;
  localparam logic [2:0] REG_FLIP   = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_RMASK  = 3'd4;
  localparam logic [2:0] REG_GMASK  = 3'd5;
  localparam logic [2:0] REG_BMASK  = 3'd6;
  localparam logic [2:0] REG_AMASK  = 3'd7;

  // Job kinds passed from front to back
  localparam logic [1:0] KIND_PAL1 = 2'd0;
  localparam logic [1:0] KIND_PAL2 = 2'd1;
  localparam logic [1:0] KIND_MASK = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  // Job queue depth
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [1:0]  flip;
    logic [12:0] width;
    logic [12:0] height;
  } geom_t;

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [31:0] alpha;
  } masks_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  idx0;
    logic [7:0]  idx1;
    logic [31:0] word;
    logic [11:0] dx0;
    logic [11:0] dx1;
    logic [11:0] dy;
    logic        end0;
    logic        end1;
  } job_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  addr;
    logic [23:0] data;
  } pal_wr_t;

endpackage

// ===== rtl/bpd_fifo.sv =====
`timescale 1ns / 1ps
module bpd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bpd_pkg::job_t   push_data,
  input  logic            pop,
  output bpd_pkg::job_t   head,
  output logic            full,
  output logic            empty
);
  localparam int PW = $clog2(bpd_pkg::QDEPTH);

  bpd_pkg::job_t mem_r [bpd_pkg::QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign full  = (count_r == (PW+1)'(bpd_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end
endmodule

// ===== rtl/bpd_front.sv =====
`timescale 1ns / 1ps
module bpd_front #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [7:0]        in_data_byte,
  input  logic [7:0]        in_pal_red,
  input  logic [7:0]        in_pal_green,
  input  logic [7:0]        in_pal_blue,
  input  bpd_pkg::geom_t    geom,
  input  logic              back_busy,
  input  logic              q_full,
  input  logic              q_empty,
  output logic              q_push,
  output bpd_pkg::job_t     q_data,
  output bpd_pkg::pal_wr_t  pal_wr
);
  localparam int XW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 1);
  localparam int BW = $clog2(MAX_WIDTH * 4 + 1);
  localparam int CW = $clog2(PALETTE_DEPTH + 1);
  localparam logic [15:0] MAXW16 = 16'(MAX_WIDTH);
  localparam logic [15:0] MAXH16 = 16'(MAX_HEIGHT);

  logic [23:0]   gather_r, gather_nxt;
  logic [1:0]    bip_r, bip_nxt;
  logic [BW-1:0] bir_r, bir_nxt;
  logic [XW-1:0] column_r, column_nxt;
  logic [YW-1:0] row_r, row_nxt;
  logic [CW-1:0] pcount_r, pcount_nxt;
  logic          err_r, err_nxt;
  logic          done_r, done_nxt;

  logic          acc;
  logic [15:0]   w16, h16, wc16, hc16;
  logic [XW-1:0] img_w;
  logic [YW-1:0] img_h;
  logic [2:0]    fmt;
  logic [XW+5:0] row_bits, rnd;
  logic [BW-1:0] stride;
  logic [XW-1:0] col1;
  logic          two;
  logic [3:0]    hi, lo;
  logic          bad;
  logic [4:0]    sh;
  logic [31:0]   word;
  logic          last_row;
  logic [BW-1:0] bir_inc;

  // Hold palette writes until no queued pixel can still read the palette
  assign in_stall = q_full ||
                    (in_func == bpd_pkg::FUNC_PAL && (back_busy || !q_empty));
  assign acc = in_valid && !in_stall;

  // Clamp geometry and derive the padded row length
  always_comb begin
    w16  = {3'b000, geom.width};
    h16  = {3'b000, geom.height};
    wc16 = (w16 == '0) ? 16'd1 : ((w16 > MAXW16) ? MAXW16 : w16);
    hc16 = (h16 == '0) ? 16'd1 : ((h16 > MAXH16) ? MAXH16 : h16);
    img_w = wc16[XW-1:0];
    img_h = hc16[YW-1:0];
    fmt  = (geom.fmt > bpd_pkg::FMT_RGB32) ? bpd_pkg::FMT_RGB32 : geom.fmt;
    case (fmt)
      bpd_pkg::FMT_PAL4:  row_bits = (XW+6)'(img_w) << 2;
      bpd_pkg::FMT_PAL8:  row_bits = (XW+6)'(img_w) << 3;
      bpd_pkg::FMT_RGB16: row_bits = (XW+6)'(img_w) << 4;
      bpd_pkg::FMT_RGB24: row_bits = ((XW+6)'(img_w) << 4) + ((XW+6)'(img_w) << 3);
      default:            row_bits = (XW+6)'(img_w) << 5;
    endcase
    rnd    = row_bits + (XW+6)'(31);
    stride = BW'({rnd >> 5, 2'b00});
  end

  // Per-byte decode and counter update
  always_comb begin
    gather_nxt = gather_r;
    bip_nxt    = bip_r;
    bir_nxt    = bir_r;
    column_nxt = column_r;
    row_nxt    = row_r;
    pcount_nxt = pcount_r;
    err_nxt    = err_r;
    done_nxt   = done_r;
    q_push     = 1'b0;
    pal_wr.we   = 1'b0;
    pal_wr.addr = 8'(pcount_r);
    pal_wr.data = {in_pal_red, in_pal_green, in_pal_blue};

    col1     = column_r + 1'b1;
    two      = ((XW+1)'(column_r) + 1'b1) < (XW+1)'(img_w);
    hi       = in_data_byte[7:4];
    lo       = in_data_byte[3:0];
    sh       = {bip_r, 3'b000};
    word     = {8'h00, gather_r} | (32'(in_data_byte) << sh);
    last_row = (row_r == img_h - 1'b1);
    bir_inc  = bir_r + 1'b1;
    bad      = 1'b0;

    q_data.kind = bpd_pkg::KIND_PAL1;
    q_data.idx0 = (fmt == bpd_pkg::FMT_PAL4) ? {4'h0, hi} : in_data_byte;
    q_data.idx1 = {4'h0, lo};
    q_data.word = word;
    q_data.dx0  = geom.flip[1] ? 12'(img_w - 1'b1 - column_r) : 12'(column_r);
    q_data.dx1  = geom.flip[1] ? 12'(img_w - 1'b1 - col1) : 12'(col1);
    q_data.dy   = geom.flip[0] ? 12'(row_r) : 12'(img_h - 1'b1 - row_r);
    q_data.end0 = last_row && (column_r == img_w - 1'b1);
    q_data.end1 = last_row && (col1 == img_w - 1'b1);

    if (acc) begin
      case (in_func)
        bpd_pkg::FUNC_START: begin
          gather_nxt = '0;
          bip_nxt    = '0;
          bir_nxt    = '0;
          column_nxt = '0;
          row_nxt    = '0;
          pcount_nxt = '0;
          err_nxt    = 1'b0;
          done_nxt   = 1'b0;
        end
        bpd_pkg::FUNC_PAL: begin
          if (pcount_r < CW'(PALETTE_DEPTH)) begin
            pal_wr.we  = 1'b1;
            pcount_nxt = pcount_r + 1'b1;
          end
        end
        bpd_pkg::FUNC_PIX: begin
          if (!err_r && !done_r) begin
            if (column_r < img_w) begin
              if (fmt == bpd_pkg::FMT_PAL4) begin
                bad = (9'(hi) >= 9'(pcount_r)) || (two && (9'(lo) >= 9'(pcount_r)));
                q_push = 1'b1;
                if (bad) begin
                  q_data.kind = bpd_pkg::KIND_BAD;
                end else begin
                  q_data.kind = two ? bpd_pkg::KIND_PAL2 : bpd_pkg::KIND_PAL1;
                  column_nxt  = two ? column_r + XW'(2) : col1;
                end
              end else if (fmt == bpd_pkg::FMT_PAL8) begin
                bad    = 9'(in_data_byte) >= 9'(pcount_r);
                q_push = 1'b1;
                if (bad) q_data.kind = bpd_pkg::KIND_BAD;
                else     column_nxt  = col1;
              end else if (3'(bip_r) + 3'd1 < fmt) begin
                gather_nxt = word[23:0];
                bip_nxt    = bip_r + 1'b1;
              end else begin
                q_push      = 1'b1;
                q_data.kind = bpd_pkg::KIND_MASK;
                gather_nxt  = '0;
                bip_nxt     = '0;
                column_nxt  = col1;
              end
            end
            if (bad) begin
              err_nxt = 1'b1;
            end else if (bir_inc >= stride) begin
              bir_nxt    = '0;
              column_nxt = '0;
              bip_nxt    = '0;
              gather_nxt = '0;
              row_nxt    = row_r + 1'b1;
              if ((row_r + 1'b1) >= img_h) done_nxt = 1'b1;
            end else begin
              bir_nxt = bir_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Register decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r <= '0;
      bip_r    <= '0;
      bir_r    <= '0;
      column_r <= '0;
      row_r    <= '0;
      pcount_r <= '0;
      err_r    <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      gather_r <= gather_nxt;
      bip_r    <= bip_nxt;
      bir_r    <= bir_nxt;
      column_r <= column_nxt;
      row_r    <= row_nxt;
      pcount_r <= pcount_nxt;
      err_r    <= err_nxt;
      done_r   <= done_nxt;
    end
  end
endmodule

// ===== rtl/bpd_back.sv =====
`timescale 1ns / 1ps
module bpd_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  bpd_pkg::job_t     q_head,
  output logic              q_pop,
  input  bpd_pkg::pal_wr_t  pal_wr,
  input  bpd_pkg::masks_t   masks,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_pixel_red,
  output logic [15:0]       out_pixel_green,
  output logic [15:0]       out_pixel_blue,
  output logic [15:0]       out_pixel_alpha,
  output logic [11:0]       out_dest_x,
  output logic [11:0]       out_dest_y,
  output logic              out_bad_index,
  output logic              out_image_end,
  output logic              out_run_end
);
  localparam int AW = $clog2(PALETTE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAL0 = 3'd1;
  localparam logic [2:0] S_PAL1 = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  bpd_pkg::job_t job_r;

  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] rd_data_r;
  logic        rd_en;
  logic [AW-1:0] rd_addr;

  logic [31:0] mask_v [4];
  logic [31:0] rem_r [4];
  logic [15:0] quo_r [4];
  logic        div_init, div_step;

  logic        out_free, load_out;
  logic [15:0] res_r, res_g, res_b, res_a;
  logic [11:0] res_x, res_y;
  logic        res_bad, res_end, res_run;
  logic [15:0] chan_q [4];

  assign mask_v[0] = masks.red;
  assign mask_v[1] = masks.green;
  assign mask_v[2] = masks.blue;
  assign mask_v[3] = masks.alpha;

  assign out_free  = !out_valid_r || !out_stall;
  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Zero masks give the fixed value instead of the quotient
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (mask_v[c] == '0) chan_q[c] = (c == 3) ? 16'hFFFF : 16'h0000;
      else                 chan_q[c] = quo_r[c];
    end
  end

  // Sequence jobs into results
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = q_head.idx0[AW-1:0];
    div_init  = 1'b0;
    div_step  = 1'b0;
    load_out  = 1'b0;
    res_r = {rd_data_r[23:16], rd_data_r[23:16]};
    res_g = {rd_data_r[15:8], rd_data_r[15:8]};
    res_b = {rd_data_r[7:0], rd_data_r[7:0]};
    res_a = 16'hFFFF;
    res_x = job_r.dx0;
    res_y = job_r.dy;
    res_bad = 1'b0;
    res_end = job_r.end0;
    res_run = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          case (q_head.kind)
            bpd_pkg::KIND_BAD: begin
              load_out = 1'b1;
              res_r = '0;
              res_g = '0;
              res_b = '0;
              res_a = '0;
              res_x = q_head.dx0;
              res_y = q_head.dy;
              res_bad = 1'b1;
              res_end = 1'b0;
            end
            bpd_pkg::KIND_MASK: begin
              div_init  = 1'b1;
              cnt_nxt   = '0;
              state_nxt = S_DIV;
            end
            default: begin
              rd_en     = 1'b1;
              state_nxt = S_PAL0;
            end
          endcase
        end
      end
      S_PAL0: begin
        if (out_free) begin
          load_out = 1'b1;
          res_run  = (job_r.kind == bpd_pkg::KIND_PAL1);
          if (job_r.kind == bpd_pkg::KIND_PAL2) begin
            rd_en     = 1'b1;
            rd_addr   = job_r.idx1[AW-1:0];
            state_nxt = S_PAL1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PAL1: begin
        res_x = job_r.dx1;
        res_end = job_r.end1;
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        div_step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 4'hF) state_nxt = S_DONE;
      end
      S_DONE: begin
        res_r = chan_q[0];
        res_g = chan_q[1];
        res_b = chan_q[2];
        res_a = chan_q[3];
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  // Palette storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (pal_wr.we) pal_mem[pal_wr.addr[AW-1:0]] <= pal_wr.data;
    if (rd_en) rd_data_r <= pal_mem[rd_addr];
  end

  // Restoring dividers, one quotient bit per cycle in each channel
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      logic [31:0] x;
      logic [47:0] n;
      logic [32:0] t;
      logic        ge;
      x  = q_head.word & mask_v[c];
      n  = {x, 16'h0000} - {16'h0000, x};
      t  = {rem_r[c], quo_r[c][15]};
      ge = (t >= {1'b0, mask_v[c]});
      if (div_init) begin
        rem_r[c] <= n[47:16];
        quo_r[c] <= n[15:0];
      end else if (div_step) begin
        rem_r[c] <= ge ? 32'(t - {1'b0, mask_v[c]}) : t[31:0];
        quo_r[c] <= {quo_r[c][14:0], ge};
      end
    end
  end

  // Capture job and result payload
  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_head;
    if (load_out) begin
      out_pixel_red   <= res_r;
      out_pixel_green <= res_g;
      out_pixel_blue  <= res_b;
      out_pixel_alpha <= res_a;
      out_dest_x      <= res_x;
      out_dest_y      <= res_y;
      out_bad_index   <= res_bad;
      out_image_end   <= res_end;
      out_run_end     <= res_run;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ===== rtl/bmp_pixel_row_decoder_top.sv =====
`timescale 1ns / 1ps
// BMP pixel-data decoder for uncompressed 4/8 bpp palette and 16/24/32 bpp
// masked images.
// Input channel (in_valid / in_stall): one transfer per func code: start a new
// image, append a palette entry, or one pixel-data byte in file order.
// Output channel (out_valid / out_stall): one transfer per decoded pixel with
// colors as 16-bit fractions, destination x,y and status flags; out_run_end
// marks the last pixel caused by one input byte.
// The user must write registers over the APB port only while the block is
// idle; the block does not enforce this. A front stage tracks row, column and
// padding at one byte per cycle while in_stall is low and queues pixel jobs;
// a back stage turns jobs into pixels. Palette pixels pass the job queue, the
// registered palette read and the output register; a second 4 bpp pixel
// follows from a second palette read. Masked pixels go through four restoring
// dividers that produce one quotient bit per cycle. The back stage takes a new
// job only when idle; the 4-entry job queue absorbs bursts, and palette appends
// wait until the queue and back stage are empty.
// Reset clears all counters, the palette count and the output valid; palette
// contents are undefined until written. When the receiver stalls, the
// output holds and the queue fills, then in_stall rises.
module bmp_pixel_row_decoder_top #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_pal_red,
  input  logic [7:0]  in_pal_green,
  input  logic [7:0]  in_pal_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel_red,
  output logic [15:0] out_pixel_green,
  output logic [15:0] out_pixel_blue,
  output logic [15:0] out_pixel_alpha,
  output logic [11:0] out_dest_x,
  output logic [11:0] out_dest_y,
  output logic        out_bad_index,
  output logic        out_image_end,
  output logic        out_run_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [2:0]  fmt_r;
  logic [1:0]  flip_r;
  logic [12:0] width_r, height_r;
  logic [31:0] rmask_r, gmask_r, bmask_r, amask_r;
  logic [2:0]  reg_idx;
  logic        wr_en;

  bpd_pkg::geom_t   geom;
  bpd_pkg::masks_t  masks;
  bpd_pkg::job_t    q_data, q_head;
  bpd_pkg::pal_wr_t pal_wr;
  logic q_push, q_pop, q_full, q_empty, back_busy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= bpd_pkg::FMT_RGB24;
      flip_r   <= '0;
      width_r  <= 13'd1;
      height_r <= 13'd1;
      rmask_r  <= 32'h00FF_0000;
      gmask_r  <= 32'h0000_FF00;
      bmask_r  <= 32'h0000_00FF;
      amask_r  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        bpd_pkg::REG_FMT:    fmt_r    <= pwdata[2:0];
        bpd_pkg::REG_FLIP:   flip_r   <= pwdata[1:0];
        bpd_pkg::REG_WIDTH:  width_r  <= pwdata[12:0];
        bpd_pkg::REG_HEIGHT: height_r <= pwdata[12:0];
        bpd_pkg::REG_RMASK:  rmask_r  <= pwdata;
        bpd_pkg::REG_GMASK:  gmask_r  <= pwdata;
        bpd_pkg::REG_BMASK:  bmask_r  <= pwdata;
        default:             amask_r  <= pwdata;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      bpd_pkg::REG_FMT:    prdata = {29'd0, fmt_r};
      bpd_pkg::REG_FLIP:   prdata = {30'd0, flip_r};
      bpd_pkg::REG_WIDTH:  prdata = {19'd0, width_r};
      bpd_pkg::REG_HEIGHT: prdata = {19'd0, height_r};
      bpd_pkg::REG_RMASK:  prdata = rmask_r;
      bpd_pkg::REG_GMASK:  prdata = gmask_r;
      bpd_pkg::REG_BMASK:  prdata = bmask_r;
      default:             prdata = amask_r;
    endcase
  end

  assign geom.fmt    = fmt_r;
  assign geom.flip   = flip_r;
  assign geom.width  = width_r;
  assign geom.height = height_r;
  assign masks.red   = rmask_r;
  assign masks.green = gmask_r;
  assign masks.blue  = bmask_r;
  assign masks.alpha = amask_r;

  bpd_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_data_byte (in_data_byte),
    .in_pal_red   (in_pal_red),
    .in_pal_green (in_pal_green),
    .in_pal_blue  (in_pal_blue),
    .geom         (geom),
    .back_busy    (back_busy),
    .q_full       (q_full),
    .q_empty      (q_empty),
    .q_push       (q_push),
    .q_data       (q_data),
    .pal_wr       (pal_wr)
  );

  bpd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bpd_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .pal_wr          (pal_wr),
    .masks           (masks),
    .busy            (back_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_pixel_red   (out_pixel_red),
    .out_pixel_green (out_pixel_green),
    .out_pixel_blue  (out_pixel_blue),
    .out_pixel_alpha (out_pixel_alpha),
    .out_dest_x      (out_dest_x),
    .out_dest_y      (out_dest_y),
    .out_bad_index   (out_bad_index),
    .out_image_end   (out_image_end),
    .out_run_end     (out_run_end)
  );

  // Error results carry no color and never end the image
  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_pixel_alpha == 16'h0000 && !out_image_end)
    else $error("error result with color or image end");

  // Only the first pixel of a good 4 bpp byte leaves run_end low
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_end |-> !out_bad_index && out_pixel_alpha == 16'hFFFF)
    else $error("run_end low on a result that must end its run");

  // Palette writes never overlap pending pixel work
  a_pal_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    pal_wr.we |-> q_empty && !back_busy)
    else $error("palette written while pixels are pending");

  // Reset drops the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
endmodule
